@@ design/pcee_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pcee_pkg
// Shared types and constants for the palette color entry encoder.
// ============================================================================
package pcee_pkg;

    // Table sizes
    localparam int TRUECOLOR_ENTRIES = 16;
    localparam int PALETTE_ENTRIES   = 256;
    localparam int SMALL_PALETTE     = 16;

    // Entry limits at the width of a zero-extended index
    localparam logic [12:0] TC_LIMIT    = 13'(TRUECOLOR_ENTRIES);
    localparam logic [12:0] PAL8_LIMIT  = 13'(PALETTE_ENTRIES);
    localparam logic [12:0] PAL4_LIMIT  = 13'(SMALL_PALETTE);

    // Luminance weights (sum to 65536)
    localparam logic [31:0] LUMA_R = 32'd19595;
    localparam logic [31:0] LUMA_G = 32'd38470;
    localparam logic [31:0] LUMA_B = 32'd7471;

    // Palette flag bits
    localparam logic [15:0] INTENSITY_BIT = 16'h0001;
    localparam logic [15:0] DEPTH8_FLAG   = 16'h1000;

    // Configuration register indexes
    localparam logic [1:0] REG_DEPTH_MODE     = 2'd0;
    localparam logic [1:0] REG_INVERT_COLORS  = 2'd1;
    localparam logic [1:0] REG_GRAYSCALE_MODE = 2'd2;

    // Table selects
    localparam logic TABLE_TRUECOLOR = 1'b0;
    localparam logic TABLE_PALETTE   = 1'b1;

    // Write status
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [1:0] {
        DEPTH_4BPP  = 2'd0,
        DEPTH_8BPP  = 2'd1,
        DEPTH_16BPP = 2'd2
    } depth_t;

    typedef struct packed {
        depth_t depth_mode;
        logic   invert_colors;
        logic   grayscale_mode;
    } cfg_t;

    typedef struct packed {
        logic        status;
        logic        target_table;
        logic [7:0]  slot;
        logic [15:0] entry_word;
    } result_t;

endpackage

@@ design/pcee_color_xform.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pcee_color_xform
// Optional channel inversion followed by optional weighted grayscale.
// ============================================================================
module pcee_color_xform
    import pcee_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out
);

    logic [15:0] red_inv;
    logic [15:0] green_inv;
    logic [15:0] blue_inv;
    logic [31:0] luma_sum;
    logic [15:0] luma;

    // Invert: 0xffff minus a level is its complement
    assign red_inv   = cfg.invert_colors ? ~red_in   : red_in;
    assign green_inv = cfg.invert_colors ? ~green_in : green_in;
    assign blue_inv  = cfg.invert_colors ? ~blue_in  : blue_in;

    // Weighted luminance; weights sum to 2^16 so the sum fits 32 bits
    assign luma_sum = (32'(red_inv) * LUMA_R) + (32'(green_inv) * LUMA_G)
                    + (32'(blue_inv) * LUMA_B);
    assign luma     = luma_sum[31:16];

    // Select grayscale or color
    assign red_out   = cfg.grayscale_mode ? luma : red_inv;
    assign green_out = cfg.grayscale_mode ? luma : green_inv;
    assign blue_out  = cfg.grayscale_mode ? luma : blue_inv;

endmodule

@@ design/pcee_entry_pack.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pcee_entry_pack
// Range check of the entry index and RGB565 packing for the target table.
// ============================================================================
module pcee_entry_pack
    import pcee_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [11:0] entry_index,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    output result_t     result
);

    logic [12:0] index_ext;
    logic [15:0] word565;
    logic [15:0] pal_word;

    assign index_ext = {1'b0, entry_index};

    // Take the top 5/6/5 bits of each channel
    assign word565 = {red[15:11], green[15:10], blue[15:11]};

    // Palette word: intensity bit, depth flag on entry zero at 8 bpp
    always_comb
    begin
        pal_word = word565 | INTENSITY_BIT;
        if (entry_index == 12'd0 && cfg.depth_mode == DEPTH_8BPP)
        begin
            pal_word = pal_word | DEPTH8_FLAG;
        end
    end

    // Decode depth and reject out-of-range indexes
    always_comb
    begin
        result = '{status: STATUS_REJECT, target_table: TABLE_TRUECOLOR,
                   slot: 8'd0, entry_word: 16'd0};
        unique case (cfg.depth_mode)
            DEPTH_16BPP:
            begin
                if (index_ext < TC_LIMIT)
                begin
                    result.status       = STATUS_OK;
                    result.target_table = TABLE_TRUECOLOR;
                    result.slot         = entry_index[7:0];
                    result.entry_word   = word565;
                end
            end
            DEPTH_8BPP:
            begin
                if (index_ext < PAL8_LIMIT)
                begin
                    result.status       = STATUS_OK;
                    result.target_table = TABLE_PALETTE;
                    result.slot         = entry_index[7:0];
                    result.entry_word   = pal_word;
                end
            end
            DEPTH_4BPP:
            begin
                if (index_ext < PAL4_LIMIT)
                begin
                    result.status       = STATUS_OK;
                    result.target_table = TABLE_PALETTE;
                    result.slot         = entry_index[7:0];
                    result.entry_word   = pal_word;
                end
            end
            default:
            begin
                result.status = STATUS_REJECT;
            end
        endcase
    end

endmodule

@@ design/palette_color_entry_encoder_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// palette_color_entry_encoder_unit
// Color-map write encoder: index plus 16-bit RGB in, packed table entry out.
// ============================================================================
// Each request goes into the input register; inversion, grayscale, range
// check and RGB565 packing then run in one combinational pass into the
// result register. A new request is accepted every cycle while results are
// taken; the result register and the input register let one request wait
// while the next is taken in. The grayscale path (three constant multiplies
// and their sum) sets the cycle time. Configuration registers are written
// through cfg_write/cfg_index/cfg_data and must only change while no
// request is in flight.
module palette_color_entry_encoder_unit
    import pcee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    // Request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] entry_index,
    input  logic [15:0] red_level,
    input  logic [15:0] green_level,
    input  logic [15:0] blue_level,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic        target_table,
    output logic [7:0]  slot,
    output logic [15:0] entry_word
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [11:0] index_reg;
    logic [15:0] red_reg;
    logic [15:0] green_reg;
    logic [15:0] blue_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic [15:0] red_x;
    logic [15:0] green_x;
    logic [15:0] blue_x;
    logic        out_advance;
    logic        in_advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_mode     <= DEPTH_16BPP;
            cfg_reg.invert_colors  <= 1'b0;
            cfg_reg.grayscale_mode <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEPTH_MODE:     cfg_reg.depth_mode     <= depth_t'(cfg_data);
                REG_INVERT_COLORS:  cfg_reg.invert_colors  <= cfg_data[0];
                REG_GRAYSCALE_MODE: cfg_reg.grayscale_mode <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Advance the result stage when it is empty or being taken
    assign out_advance = !out_valid_reg || !out_stall;
    assign in_advance  = !in_valid_reg || out_advance;
    assign in_stall    = !in_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && in_valid)
        begin
            index_reg <= entry_index;
            red_reg   <= red_level;
            green_reg <= green_level;
            blue_reg  <= blue_level;
        end
    end

    pcee_color_xform u_xform (
        .cfg       (cfg_reg),
        .red_in    (red_reg),
        .green_in  (green_reg),
        .blue_in   (blue_reg),
        .red_out   (red_x),
        .green_out (green_x),
        .blue_out  (blue_x)
    );

    pcee_entry_pack u_pack (
        .cfg         (cfg_reg),
        .entry_index (index_reg),
        .red         (red_x),
        .green       (green_x),
        .blue        (blue_x),
        .result      (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign target_table = result_reg.target_table;
    assign slot         = result_reg.slot;
    assign entry_word   = result_reg.entry_word;

`ifndef NO_ASSERTIONS
    // A stall only arises with both stages full and the result held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    // An accepted request lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_valid_reg)
        else $error("accepted request lost");

    // A rejected write carries no table, slot or word
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_REJECT) |->
            (target_table == TABLE_TRUECOLOR && slot == 8'd0 && entry_word == 16'd0))
        else $error("rejected write has nonzero fields");

    // Hardware palette words always carry the intensity bit
    a_palette_intensity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK && target_table == TABLE_PALETTE) |->
            entry_word[0])
        else $error("palette word missing intensity bit");

    // True-color slots stay inside the pseudo-palette
    a_truecolor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK && target_table == TABLE_TRUECOLOR) |->
            ({5'd0, slot} < TC_LIMIT))
        else $error("true-color slot out of range");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the palette color entry encoder.
// Sends color-map write requests through every depth, invert and grayscale
// setting. Each accepted request is predicted in a scoreboard, and every
// result is compared field by field with the oldest prediction. Both sides
// idle and stall at random, with one long receiver hold-off.
// ============================================================================
module testbench;
    import pcee_pkg::*;

    localparam logic [1:0] REG_UNUSED       = 2'd3;
    localparam logic [1:0] DEPTH_UNUSED     = 2'd3;
    localparam int         IDLE_MAX         = 16;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         PHASE_COUNT      = 16;
    localparam int         ITEMS_PER_PHASE  = 115;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers, predicted entries in order
    // ------------------------------------------------------------------------
    class entry_scoreboard;
        logic [1:0] depth_mode;
        logic       invert_colors;
        logic       grayscale_mode;
        result_t    expected_entries[$];
        int         errors;

        function new();
            depth_mode     = DEPTH_16BPP;
            invert_colors  = 1'b0;
            grayscale_mode = 1'b0;
            errors         = 0;
        endfunction

        // Mirror a register write, masked to the register width
        function void set_register(logic [1:0] idx, logic [1:0] data);
            case (idx)
                REG_DEPTH_MODE:     depth_mode     = data;
                REG_INVERT_COLORS:  invert_colors  = data[0];
                REG_GRAYSCALE_MODE: grayscale_mode = data[0];
                default: ;
            endcase
        endfunction

        // Predict the table entry for one request
        function result_t encode_entry(logic [11:0] idx, logic [15:0] r_in,
                                       logic [15:0] g_in, logic [15:0] b_in);
            logic [15:0] r;
            logic [15:0] g;
            logic [15:0] b;
            logic [31:0] luma;
            logic [15:0] packed_rgb;
            result_t     res;
            r = r_in;
            g = g_in;
            b = b_in;
            if (invert_colors)
            begin
                r = 16'hffff - r;
                g = 16'hffff - g;
                b = 16'hffff - b;
            end
            if (grayscale_mode)
            begin
                luma = LUMA_R * r + LUMA_G * g + LUMA_B * b;
                r = luma[31:16];
                g = luma[31:16];
                b = luma[31:16];
            end
            packed_rgb = {r[15:11], g[15:10], b[15:11]};
            res = '0;
            res.status = STATUS_REJECT;
            case (depth_mode)
                DEPTH_16BPP:
                begin
                    if (idx < TRUECOLOR_ENTRIES)
                    begin
                        res.status       = STATUS_OK;
                        res.target_table = TABLE_TRUECOLOR;
                        res.slot         = idx[7:0];
                        res.entry_word   = packed_rgb;
                    end
                end
                DEPTH_4BPP, DEPTH_8BPP:
                begin
                    if (idx < ((depth_mode == DEPTH_8BPP) ? PALETTE_ENTRIES : SMALL_PALETTE))
                    begin
                        res.status       = STATUS_OK;
                        res.target_table = TABLE_PALETTE;
                        res.slot         = idx[7:0];
                        res.entry_word   = packed_rgb | INTENSITY_BIT;
                        // entry 0 of an 8 bpp palette carries the depth code
                        if (idx == 12'd0 && depth_mode == DEPTH_8BPP)
                            res.entry_word = res.entry_word | DEPTH8_FLAG;
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void note_request(logic [11:0] idx, logic [15:0] r,
                                   logic [15:0] g, logic [15:0] b);
            expected_entries.push_back(encode_entry(idx, r, g, b));
        endfunction

        task check_result(result_t got);
            result_t want;
            if (expected_entries.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
            end
            else
            begin
                want = expected_entries.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0h want %0h",
                                              got.status, want.status));
                if (got.target_table !== want.target_table)
                    report_mismatch($sformatf("target_table got %0h want %0h",
                                              got.target_table, want.target_table));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("slot got %0h want %0h",
                                              got.slot, want.slot));
                if (got.entry_word !== want.entry_word)
                    report_mismatch($sformatf("entry_word got %0h want %0h",
                                              got.entry_word, want.entry_word));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [1:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] entry_index = '0;
    logic [15:0] red_level = '0;
    logic [15:0] green_level = '0;
    logic [15:0] blue_level = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic        target_table;
    logic [7:0]  slot;
    logic [15:0] entry_word;

    palette_color_entry_encoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .entry_index  (entry_index),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .target_table (target_table),
        .slot         (slot),
        .entry_word   (entry_word)
    );

    entry_scoreboard sb = new();
    int  idle_cycles = 0;
    int  stall_left = 0;
    int  rx_stall_max = 0;
    int  tx_gap_max = 0;
    bit  long_hold_req = 1'b0;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: note accepted requests, check accepted results, count idle
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && !in_stall)
            begin
                sb.note_request(entry_index, red_level, green_level, blue_level);
                idle_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                got.status       = status;
                got.target_table = target_table;
                got.slot         = slot;
                got.entry_word   = entry_word;
                sb.check_result(got);
                stall_left  = $urandom_range(0, rx_stall_max);
                idle_cycles = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall a drawn number of cycles after each result
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                out_stall = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // Write one configuration register while the block is idle
    task write_register(logic [1:0] idx, logic [1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Offer one request after a gap and hold it until accepted
    task send_request(logic [11:0] idx, logic [15:0] r, logic [15:0] g,
                      logic [15:0] b, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        entry_index = idx;
        red_level   = r;
        green_level = g;
        blue_level  = b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every predicted entry has come back
    task wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_entries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function logic [15:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    // Favor indexes near the table limits of every depth
    function logic [11:0] pick_index();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1, 2:    return 12'($urandom_range(1, 15));
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       return 12'd15;
                    1:       return 12'd16;
                    2:       return 12'd255;
                    default: return 12'd256;
                endcase
            end
            4, 5:    return 12'($urandom_range(16, 255));
            6:       return 12'hfff;
            default: return 12'($urandom());
        endcase
    endfunction

    // Extremes of index and channel levels
    task send_directed();
        send_request(12'd0,   16'h0000, 16'h0000, 16'h0000, 0);
        send_request(12'd0,   16'hffff, 16'hffff, 16'hffff, 0);
        send_request(12'd15,  16'hffff, 16'h0000, 16'h0000, 0);
        send_request(12'd16,  16'h0000, 16'hffff, 16'h0000, 0);
        send_request(12'd255, 16'h0000, 16'h0000, 16'hffff, 1);
        send_request(12'd256, 16'haaaa, 16'h5555, 16'haaaa, 0);
        send_request(12'hfff, 16'h5555, 16'haaaa, 16'h5555, 0);
        send_request(12'd1,   16'h07ff, 16'h03ff, 16'h07ff, 2);
        send_request(12'd7,   16'hf800, 16'hfc00, 16'hf800, 0);
        send_request(12'd0,   16'h8000, 16'h4000, 16'h0800, 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int         phase;
        int         item;
        int         gap;
        int         profile;
        logic [1:0] depth;
        logic       inv;
        logic       gray;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting first, then inverted grayscale settings at 4 bpp and 8 bpp
        send_directed();
        wait_for_drain();
        write_register(REG_DEPTH_MODE, DEPTH_4BPP);
        write_register(REG_INVERT_COLORS, 2'd1);
        write_register(REG_GRAYSCALE_MODE, 2'd1);
        send_directed();
        wait_for_drain();
        write_register(REG_DEPTH_MODE, DEPTH_8BPP);
        send_directed();
        wait_for_drain();

        // a write to the unused index changes nothing
        write_register(REG_UNUSED, 2'($urandom()));

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            depth = 2'(phase / 4);
            inv   = phase[1];
            gray  = phase[0];
            write_register(REG_DEPTH_MODE, depth);
            write_register(REG_INVERT_COLORS, {1'($urandom()), inv});
            write_register(REG_GRAYSCALE_MODE, {1'($urandom()), gray});

            // vary who idles from phase to phase
            profile = (phase + phase / 4) % 4;
            tx_gap_max   = profile[0] ? IDLE_MAX : 0;
            rx_stall_max = profile[1] ? IDLE_MAX : 0;

            if (phase == 1)
                long_hold_req = 1'b1;

            for (item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                gap = $urandom_range(0, tx_gap_max);
                // keep offering back to back while the receiver holds off
                if (phase == 1 && item < 40)
                    gap = 0;
                if (item == 60 && phase % 5 == 2)
                    wait_for_drain();
                send_request(pick_index(), pick_level(), pick_level(), pick_level(), gap);
            end
            wait_for_drain();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_entries.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/pcee_pkg.sv
design/pcee_color_xform.sv
design/pcee_entry_pack.sv
design/palette_color_entry_encoder_unit.sv
sim/testbench.sv
